/* hdl/nptb_pkg.sv */
// Shared types and constants for the nested page table builder.
`default_nettype none
package nptb_pkg;
   localparam int ENTRY_BITS = 9;
   localparam int ENTRIES = 512;
   localparam logic [1:0] CMD_CREATE = 2'd0;
   localparam logic [1:0] CMD_MAP = 2'd1;
   localparam logic [1:0] CMD_DESTROY = 2'd2;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NOMEM = 2'd1;
   localparam logic [1:0] ST_INVAL = 2'd2;
   localparam logic [63:0] ADDR_MASK = 64'h000f_ffff_ffff_f000;
   localparam int BIT_P = 0;
   localparam int BIT_W = 1;
   localparam int BIT_U = 2;
   localparam int BIT_NX = 63;
   localparam logic [0:0] REG_POOL_BASE = 1'd0;
endpackage
`default_nettype wire

/* hdl/nested_page_table_builder.sv */
// Top level: page-table pool, allocator, map walker and teardown sequencer.
// Create allocates a page, clears it and responds; map walks each level, allocating and
// clearing a missing table, then writes the leaf and responds; destroy scans the tables
// level by level, marks them, then frees them. One item at a time. Synchronous active-high
// reset frees all pages and clears pool_base; pool contents stay undefined until written.
`default_nettype none
module nested_page_table_builder #(
   parameter int POOL_PAGES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [51:0] req_root,
   input  wire logic [47:0] req_guest_address,
   input  wire logic [51:0] req_host_address,
   input  wire logic [2:0]  req_access_flags,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [51:0]      rsp_root_address,
   output logic [4:0]       rsp_pages_in_use,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);
   import nptb_pkg::*;
   localparam int PW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
   localparam int AW = PW + ENTRY_BITS;
   localparam int CW = $clog2(POOL_PAGES + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_ALLOC, S_CLEAR, S_MRD, S_MWAIT, S_MCHK, S_LEAF,
      S_DSCAN, S_DWAIT, S_DNEXT, S_FREE, S_RESP
   } state_type;

   state_type state_ff;
   logic [63:0] mem [POOL_PAGES*ENTRIES];
   logic [63:0] rdata_ff;
   logic        we;
   logic [AW-1:0] waddr, raddr;
   logic [63:0] wdata;

   logic [51:0] base_ff;
   logic [POOL_PAGES-1:0] amap_ff, cur_ff, nxt_ff, doom_ff;
   logic [CW-1:0] count_ff;
   logic [1:0]  cmd_ff, lvl_ff;
   logic [47:0] gpa_ff;
   logic [51:0] hpa_ff;
   logic [2:0]  flg_ff;
   logic [PW-1:0] tab_ff, newp_ff;
   logic [ENTRY_BITS-1:0] idx_ff;
   logic [1:0]  st_ff;
   logic [51:0] raddr_out_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = {12'd0, base_ff};
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid;
   assign rsp_status = st_ff;
   assign rsp_root_address = raddr_out_ff;
   assign rsp_pages_in_use = 5'(count_ff);

   // page lookup: index of address in pool, or invalid
   function automatic logic [PW:0] pidx(input logic [51:0] a, input logic [51:0] b);
      logic [39:0] off;
      off = a[51:12] - b[51:12];
      if (off < 40'(POOL_PAGES)) return {1'b1, off[PW-1:0]};
      return '0;
   endfunction

   logic [PW:0] root_lk, ent_lk;
   assign root_lk = pidx(req_root, base_ff);
   assign ent_lk = pidx(rdata_ff[51:0], base_ff);

   logic          free_any;
   logic [PW-1:0] free_idx;
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = POOL_PAGES - 1; i >= 0; i--) begin
         if (!amap_ff[i]) begin
            free_any = 1'b1;
            free_idx = PW'(i);
         end
      end
   end

   logic          cur_any;
   logic [PW-1:0] cur_idx;
   always_comb begin
      cur_any = 1'b0;
      cur_idx = '0;
      for (int i = POOL_PAGES - 1; i >= 0; i--) begin
         if (cur_ff[i]) begin
            cur_any = 1'b1;
            cur_idx = PW'(i);
         end
      end
   end

   logic [ENTRY_BITS-1:0] gslot;
   always_comb begin
      unique case (lvl_ff)
         2'd3: gslot = gpa_ff[47:39];
         2'd2: gslot = gpa_ff[38:30];
         2'd1: gslot = gpa_ff[29:21];
         default: gslot = gpa_ff[20:12];
      endcase
   end

   logic [POOL_PAGES-1:0] freed;
   logic [CW-1:0] nfreed;
   always_comb begin
      freed = doom_ff & amap_ff;
      nfreed = '0;
      for (int i = 0; i < POOL_PAGES; i++) nfreed = nfreed + CW'(freed[i]);
   end

   always_comb begin
      we = 1'b0;
      waddr = {newp_ff, idx_ff};
      wdata = '0;
      raddr = {tab_ff, gslot};
      if (state_ff == S_CLEAR) we = 1'b1;
      if (state_ff == S_LEAF) begin
         // zero flags: walk done, no leaf written
         we = (flg_ff != 3'd0);
         waddr = {tab_ff, gslot};
         wdata = (64'(hpa_ff) & ADDR_MASK) | 64'(1 << BIT_P) | 64'(1 << BIT_U);
         if (flg_ff[1]) wdata[BIT_W] = 1'b1;
         if (!flg_ff[2]) wdata[BIT_NX] = 1'b1;
      end
      if (state_ff == S_ALLOC && cmd_ff == CMD_MAP) begin
         // link new table into parent entry
         we = free_any;
         waddr = {tab_ff, gslot};
         wdata = 64'({base_ff[51:12] + 40'(free_idx), 12'd0}) | 64'd7;
      end
      if (state_ff == S_DSCAN) raddr = {tab_ff, idx_ff};
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         base_ff <= '0;
         amap_ff <= '0;
         count_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr[3] == REG_POOL_BASE)
            base_ff <= csr_pwdata[51:0];
         if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_valid && req_ready) begin
               cmd_ff <= req_command;
               gpa_ff <= req_guest_address;
               hpa_ff <= req_host_address;
               flg_ff <= req_access_flags;
               tab_ff <= root_lk[PW-1:0];
               lvl_ff <= 2'd3;
               st_ff <= ST_OK;
               raddr_out_ff <= '0;
               cur_ff <= '0;
               nxt_ff <= '0;
               doom_ff <= '0;
               idx_ff <= '0;
               case (req_command)
                  CMD_CREATE: state_ff <= S_ALLOC;
                  CMD_MAP: begin
                     if (root_lk[PW]) state_ff <= S_MRD;
                     else begin
                        st_ff <= ST_INVAL;
                        state_ff <= S_RESP;
                     end
                  end
                  CMD_DESTROY: begin
                     if (req_root != '0 && root_lk[PW]) begin
                        cur_ff <= POOL_PAGES'(1) << root_lk[PW-1:0];
                        state_ff <= S_DNEXT;
                     end else state_ff <= S_RESP;
                  end
                  default: begin
                     st_ff <= ST_INVAL;
                     state_ff <= S_RESP;
                  end
               endcase
            end
            S_ALLOC: begin
               if (!free_any) begin
                  st_ff <= ST_NOMEM;
                  state_ff <= S_RESP;
               end else begin
                  amap_ff[free_idx] <= 1'b1;
                  count_ff <= count_ff + 1'b1;
                  newp_ff <= free_idx;
                  idx_ff <= '0;
                  if (cmd_ff == CMD_CREATE)
                     raddr_out_ff <= {base_ff[51:12] + 40'(free_idx), 12'd0};
                  state_ff <= S_CLEAR;
               end
            end
            S_CLEAR: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == ENTRY_BITS'(ENTRIES - 1)) begin
                  if (cmd_ff == CMD_CREATE) state_ff <= S_RESP;
                  else begin
                     tab_ff <= newp_ff;
                     lvl_ff <= lvl_ff - 1'b1;
                     state_ff <= (lvl_ff == 2'd1) ? S_LEAF : S_MRD;
                  end
               end
            end
            S_MRD: state_ff <= S_MWAIT;
            S_MWAIT: state_ff <= S_MCHK;
            S_MCHK: begin
               if (!rdata_ff[BIT_P]) state_ff <= S_ALLOC;
               else if (!ent_lk[PW]) begin
                  st_ff <= ST_INVAL;
                  state_ff <= S_RESP;
               end else begin
                  tab_ff <= ent_lk[PW-1:0];
                  lvl_ff <= lvl_ff - 1'b1;
                  state_ff <= (lvl_ff == 2'd1) ? S_LEAF : S_MRD;
               end
            end
            S_LEAF: begin
               if (flg_ff == 3'd0) begin
                  st_ff <= ST_INVAL;
               end
               state_ff <= S_RESP;
            end
            S_DNEXT: begin
               if (cur_any) begin
                  cur_ff[cur_idx] <= 1'b0;
                  doom_ff[cur_idx] <= 1'b1;
                  tab_ff <= cur_idx;
                  idx_ff <= '0;
                  if (lvl_ff != 2'd0) state_ff <= S_DSCAN;
               end else if (lvl_ff == 2'd0) state_ff <= S_FREE;
               else begin
                  cur_ff <= nxt_ff;
                  nxt_ff <= '0;
                  lvl_ff <= lvl_ff - 1'b1;
               end
            end
            S_DSCAN: begin
               // read address issued this cycle; the data is registered and used in the next cycle
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == ENTRY_BITS'(ENTRIES - 1)) state_ff <= S_DWAIT;
               if (idx_ff != '0 && rdata_ff[BIT_P] && ent_lk[PW])
                  nxt_ff[ent_lk[PW-1:0]] <= 1'b1;
            end
            S_DWAIT: begin
               // last entry of the table
               if (rdata_ff[BIT_P] && ent_lk[PW]) nxt_ff[ent_lk[PW-1:0]] <= 1'b1;
               state_ff <= S_DNEXT;
            end
            S_FREE: begin
               amap_ff <= amap_ff & ~doom_ff;
               count_ff <= count_ff - nfreed;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               rsp_valid <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for the nested page table builder: directed table plus random traffic.
`timescale 1ns / 1ps
module tb;
   import nptb_pkg::*;

   localparam int POOL_PAGES = 16;
   localparam logic [63:0] MASK52 = 64'h000f_ffff_ffff_ffff;
   localparam logic [1:0] CMD_NONE = 2'd3;
   localparam int PHASES = 6;
   localparam int RAND_PER_PHASE = 200;
   localparam longint LIMIT = 40_000_000;

   typedef struct {
      logic [1:0]  status;
      logic [51:0] root_address;
      logic [4:0]  pages_in_use;
   } result_type;

   typedef struct {
      logic [1:0]  command;
      logic [51:0] root;
      logic [47:0] guest_address;
      logic [51:0] host_address;
      logic [2:0]  access_flags;
      bit          typed;
      result_type  want;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [1:0] req_command = 0;
   logic [51:0] req_root = 0;
   logic [47:0] req_guest_address = 0;
   logic [51:0] req_host_address = 0;
   logic [2:0] req_access_flags = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [1:0] rsp_status;
   logic [51:0] rsp_root_address;
   logic [4:0] rsp_pages_in_use;
   logic csr_psel = 0;
   logic csr_penable = 0;
   logic csr_pwrite = 0;
   logic [3:0] csr_paddr = 0;
   logic [63:0] csr_pwdata = 0;
   logic [63:0] csr_prdata;
   logic csr_pready;

   nested_page_table_builder #(.POOL_PAGES(POOL_PAGES)) u_top (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // shadow of the block's table pool
   logic [63:0] table_mem [POOL_PAGES*ENTRIES];
   bit          page_busy [POOL_PAGES];
   int          busy_count;
   logic [63:0] shadow_base;
   int          new_root_idx;

   result_type expected_q[$];
   row_type    dir_rows[$];
   int      live_roots[$];
   int      fail_count = 0;
   int      checked = 0;
   int      sent = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   longint  cycles = 0;

   function automatic logic [63:0] pool_addr(int i);
      return ((shadow_base & ADDR_MASK) + 64'(i) * 64'd4096) & MASK52;
   endfunction

   function automatic int pool_idx(logic [63:0] addr);
      logic [63:0] off;
      off = ((addr & ADDR_MASK) - (shadow_base & ADDR_MASK)) & MASK52;
      if ((off >> 12) >= POOL_PAGES) return -1;
      return int'(off >> 12);
   endfunction

   function automatic int grab_page();
      for (int i = 0; i < POOL_PAGES; i++) begin
         if (!page_busy[i]) begin
            page_busy[i] = 1;
            busy_count++;
            for (int j = 0; j < ENTRIES; j++) table_mem[i*ENTRIES+j] = '0;
            return i;
         end
      end
      return -1;
   endfunction

   function automatic logic [1:0] walk_map(logic [63:0] root, logic [63:0] gpa,
                                           logic [63:0] hpa, logic [2:0] flags);
      int t, p, slot;
      logic [63:0] e, leaf;
      t = pool_idx(root);
      if (t < 0) return ST_INVAL;
      for (int sh = 39; sh > 12; sh -= 9) begin
         slot = t * ENTRIES + int'((gpa >> sh) & 64'h1ff);
         e = table_mem[slot];
         if (!e[BIT_P]) begin
            p = grab_page();
            if (p < 0) return ST_NOMEM;
            e = pool_addr(p) | 64'h7;
            table_mem[slot] = e;
         end
         t = pool_idx(e & ADDR_MASK);
         if (t < 0) return ST_INVAL;
      end
      if (flags == 0) return ST_INVAL;
      leaf = (hpa & ADDR_MASK) | 64'h5;
      if (flags[1]) leaf[BIT_W] = 1;
      if (!flags[2]) leaf[BIT_NX] = 1;
      table_mem[t*ENTRIES + int'((gpa >> 12) & 64'h1ff)] = leaf;
      return ST_OK;
   endfunction

   function automatic void tear_down(logic [63:0] root);
      bit cur [POOL_PAGES];
      bit nxt [POOL_PAGES];
      bit doomed [POOL_PAGES];
      int r, c;
      logic [63:0] e;
      r = pool_idx(root);
      if (root == 0 || r < 0) return;
      for (int i = 0; i < POOL_PAGES; i++) begin
         cur[i] = 0;
         doomed[i] = 0;
      end
      cur[r] = 1;
      for (int lvl = 3; lvl >= 0; lvl--) begin
         for (int i = 0; i < POOL_PAGES; i++) nxt[i] = 0;
         for (int i = 0; i < POOL_PAGES; i++) begin
            if (cur[i]) begin
               doomed[i] = 1;
               if (lvl != 0) begin
                  for (int j = 0; j < ENTRIES; j++) begin
                     e = table_mem[i*ENTRIES+j];
                     if (e[BIT_P]) begin
                        c = pool_idx(e & ADDR_MASK);
                        if (c >= 0) nxt[c] = 1;
                     end
                  end
               end
            end
         end
         cur = nxt;
      end
      for (int i = 0; i < POOL_PAGES; i++) begin
         if (doomed[i] && page_busy[i]) begin
            page_busy[i] = 0;
            if (busy_count > 0) busy_count--;
         end
      end
   endfunction

   function automatic result_type build_step(row_type it);
      result_type res;
      int p;
      res.status = ST_OK;
      res.root_address = '0;
      new_root_idx = -1;
      case (it.command)
         CMD_CREATE: begin
            p = grab_page();
            if (p < 0) res.status = ST_NOMEM;
            else begin
               res.root_address = 52'(pool_addr(p));
               new_root_idx = p;
            end
         end
         CMD_MAP: res.status = walk_map(64'(it.root), 64'(it.guest_address),
                                        64'(it.host_address), it.access_flags);
         CMD_DESTROY: tear_down(64'(it.root));
         default: res.status = ST_INVAL;
      endcase
      res.pages_in_use = busy_count[4:0];
      return res;
   endfunction

   // drives one item; called at a rising edge, returns at the accepting edge
   task automatic send_item(row_type it);
      result_type res;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1;
      req_command <= it.command;
      req_root <= it.root;
      req_guest_address <= it.guest_address;
      req_host_address <= it.host_address;
      req_access_flags <= it.access_flags;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      res = build_step(it);
      if (it.command == CMD_CREATE && new_root_idx >= 0) live_roots.push_back(new_root_idx);
      expected_q.push_back(it.typed ? it.want : res);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (expected_q.size() > 0) @(posedge clock);
   endtask

   task automatic write_base(logic [63:0] v);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {REG_POOL_BASE, 3'b000};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      shadow_base = v & MASK52;
   endtask

   function automatic void add_row(logic [1:0] cmd, logic [51:0] root, logic [47:0] gpa,
                                   logic [51:0] hpa, logic [2:0] flags, bit typed,
                                   logic [1:0] st, logic [51:0] ra, logic [4:0] pages);
      row_type r;
      r.command = cmd;
      r.root = root;
      r.guest_address = gpa;
      r.host_address = hpa;
      r.access_flags = flags;
      r.typed = typed;
      r.want.status = st;
      r.want.root_address = ra;
      r.want.pages_in_use = pages;
      dir_rows.push_back(r);
   endfunction

   function automatic logic [47:0] pick_guest();
      logic [47:0] g;
      g = 48'({$urandom, $urandom});
      for (int l = 0; l < 4; l++) begin
         case ($urandom_range(3))
            0: g[12+9*l +: 9] = 9'd0;
            1: g[12+9*l +: 9] = 9'd1;
            2: g[12+9*l +: 9] = 9'h1ff;
            default: ;
         endcase
      end
      return g;
   endfunction

   function automatic row_type random_row();
      row_type r;
      int k, sel;
      r.typed = 0;
      r.guest_address = pick_guest();
      r.host_address = 52'({$urandom, $urandom});
      r.access_flags = 3'($urandom_range(7));
      r.root = 52'({$urandom, $urandom});
      k = $urandom_range(99);
      if (live_roots.size() == 0 && k < 80) k = 0;
      if (busy_count >= 12 && k < 80 && live_roots.size() > 0) k = 70;
      if (k < 15) r.command = CMD_CREATE;
      else if (k < 80) begin
         r.command = (k < 70) ? CMD_MAP : CMD_DESTROY;
         sel = $urandom_range(live_roots.size() - 1);
         r.root = 52'(pool_addr(live_roots[sel])) | 52'($urandom_range(4095));
         if (r.command == CMD_DESTROY) live_roots.delete(sel);
      end else if (k < 88) r.command = CMD_MAP;
      else if (k < 93) r.command = CMD_DESTROY;
      else if (k < 96) begin
         r.command = CMD_DESTROY;
         r.root = '0;
      end else r.command = CMD_NONE;
      return r;
   endfunction

   // result side: random back-pressure and in-order compare
   always @(posedge clock) begin
      result_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $error("result with nothing expected");
            fail_count++;
         end else begin
            w = expected_q.pop_front();
            checked++;
            if (rsp_status !== w.status) begin
               $error("status: expected %0d actual %0d", w.status, rsp_status);
               fail_count++;
            end
            if (rsp_root_address !== w.root_address) begin
               $error("root_address: expected %h actual %h", w.root_address,
                      rsp_root_address);
               fail_count++;
            end
            if (rsp_pages_in_use !== w.pages_in_use) begin
               $error("pages_in_use: expected %0d actual %0d", w.pages_in_use,
                      rsp_pages_in_use);
               fail_count++;
            end
         end
      end
      rsp_ready <= (recv_idle_pct > 0) ? ($urandom_range(99) >= recv_idle_pct) : 1'b1;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("nested_page_table_builder regression: fail");
         $finish;
      end
   end

   initial begin
      logic [63:0] bases [PHASES];
      logic [51:0] ones;
      ones = '1;
      bases[0] = 64'd0;
      bases[1] = 64'h000f_ffff_ffff_f000;
      bases[2] = {$urandom, $urandom} & MASK52;
      bases[3] = 64'h0000_1234_5678_9abc;
      bases[4] = 64'h000f_ffff_ffff_ffff;
      bases[5] = 64'd0;
      for (int i = 0; i < POOL_PAGES; i++) page_busy[i] = 0;
      busy_count = 0;
      shadow_base = 0;
      live_roots.push_back(0);

      // fill the pool so every page has been cleared once, then probe the edges
      for (int i = 0; i < POOL_PAGES; i++)
         add_row(CMD_CREATE, 0, 0, 0, 0, 1, ST_OK, 52'(i) * 52'd4096, 5'(i + 1));
      add_row(CMD_CREATE, 0, 0, 0, 0, 1, ST_NOMEM, 0, 5'd16);
      add_row(CMD_MAP, 52'd4096, '1, ones, 3'd7, 1, ST_NOMEM, 0, 5'd16);
      add_row(CMD_MAP, 52'hf_ffff_ffff_f000, 0, 0, 3'd7, 1, ST_INVAL, 0, 5'd16);
      add_row(CMD_NONE, ones, '1, ones, 3'd7, 1, ST_INVAL, 0, 5'd16);
      add_row(CMD_DESTROY, 0, 0, 0, 0, 1, ST_OK, 0, 5'd16);
      for (int i = 1; i < POOL_PAGES; i++)
         add_row(CMD_DESTROY, 52'(i) * 52'd4096, 0, 0, 0, 1, ST_OK, 0, 5'(16 - i));
      add_row(CMD_CREATE, 0, 0, 0, 0, 1, ST_OK, 52'd4096, 5'd2);
      add_row(CMD_MAP, 52'd4096, 0, 0, 3'd0, 0, 0, 0, 0);
      add_row(CMD_MAP, 52'd4096, 0, ones, 3'd7, 0, 0, 0, 0);
      add_row(CMD_MAP, 52'd4096, '1, ones, 3'd1, 0, 0, 0, 0);
      add_row(CMD_MAP, 52'd4096, 48'h1000, 52'h5_a5a5_a5a5_a5a5, 3'd2, 0, 0, 0, 0);
      add_row(CMD_MAP, 52'd4096, 48'h8040_2010_0000, 52'ha_5a5a_5a5a_5a5a, 3'd4, 0, 0, 0, 0);
      add_row(CMD_MAP, 52'h4fff, 48'h7fbf_dfef_f000, 52'd0, 3'd6, 0, 0, 0, 0);
      add_row(CMD_MAP, 52'd4096, 48'h0000_3fe0_0fff, ones, 3'd3, 0, 0, 0, 0);
      add_row(CMD_MAP, 52'd4096, 48'hffff_ffff_ffff, 52'd0, 3'd5, 0, 0, 0, 0);
      add_row(CMD_DESTROY, 52'd4096, 0, 0, 0, 0, 0, 0, 0);

      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph % 3)
            0: begin send_idle_pct = 33; recv_idle_pct = 48; end
            1: begin send_idle_pct = 48; recv_idle_pct = 33; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         write_base(bases[ph]);
         if (ph == 0)
            foreach (dir_rows[i]) send_item(dir_rows[i]);
         for (int n = 0; n < RAND_PER_PHASE; n++) send_item(random_row());
         drain();
      end

      repeat (100) @(posedge clock);
      $display("covered %0d items over %0d pool base settings, %0d results compared",
               sent, PHASES, checked);
      if (fail_count == 0 && expected_q.size() == 0)
         $display("nested_page_table_builder regression: pass");
      else
         $display("nested_page_table_builder regression: fail");
      $finish;
   end
endmodule
